// ===== src/egbw_pkg.sv =====
package egbw_pkg;

    // Payload word width used by the coder.
    localparam int VALUE_WIDTH = 32;
    // Bit length of a code number, 0..VALUE_WIDTH.
    localparam int LEN_W       = $clog2(VALUE_WIDTH + 1);
    // Left-justified bit string of one item (at most 63 bits).
    localparam int CODE_W      = 64;
    localparam int CNT_W       = 6;
    localparam int SHIFT_W     = 7;
    // Packer accumulator: 7 leftover bits plus 63 new bits fit in 72.
    localparam int ACC_W       = CODE_W + 8;
    localparam int ACC_CNT_W   = 7;
    // Decoupling queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_UE    = 2'd1;
    localparam logic [1:0] MODE_SE    = 2'd2;
    localparam logic [1:0] MODE_ALIGN = 2'd3;

    typedef enum logic [1:0] {
        KIND_RAW,
        KIND_GOLOMB,
        KIND_ALIGN
    } t_kind;

    // One classified item: bits left-justified in word, count of valid bits,
    // align marks a byte-align request resolved by the back end.
    typedef struct packed {
        logic [CODE_W-1:0] word;
        logic [CNT_W-1:0]  count;
        logic              align;
    } t_entry;

endpackage

// ===== src/egbw_front.sv =====
module egbw_front import egbw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_value,
    input  logic [5:0]  i_bit_count,
    output logic        o_valid,
    input  logic        i_ready,
    output t_entry      o_entry
);

    // stage 1: code number
    logic                   r_s1_valid;
    t_kind                  r_s1_kind;
    logic [VALUE_WIDTH-1:0] r_s1_x;
    logic [5:0]             r_s1_bc;
    t_kind                  n_s1_kind;
    logic [VALUE_WIDTH-1:0] n_s1_x;
    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] v2;

    // stage 2: length and placement
    logic                   r_s2_valid;
    logic [VALUE_WIDTH-1:0] r_s2_x;
    logic [SHIFT_W-1:0]     r_s2_shift;
    logic [CNT_W-1:0]       r_s2_count;
    logic                   r_s2_align;
    logic [LEN_W-1:0]       len;
    logic [SHIFT_W-1:0]     n_s2_shift;
    logic [CNT_W-1:0]       n_s2_count;

    logic s1_ready;
    logic s2_ready;

    assign s2_ready = !r_s2_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;

    assign v  = i_value[VALUE_WIDTH-1:0];
    assign v2 = {v[VALUE_WIDTH-2:0], 1'b0};

    always_comb begin
        n_s1_kind = KIND_RAW;
        n_s1_x    = v;
        unique case (i_mode)
            MODE_RAW: begin
                n_s1_kind = KIND_RAW;
                n_s1_x    = v;
            end
            MODE_UE: begin
                n_s1_kind = KIND_GOLOMB;
                n_s1_x    = v + VALUE_WIDTH'(1);
            end
            MODE_SE: begin
                n_s1_kind = KIND_GOLOMB;
                // code number plus one: 2v for positive v, 1-2v for zero and negative
                if (!v[VALUE_WIDTH-1] && (v != '0)) begin
                    n_s1_x = v2;
                end else begin
                    n_s1_x = VALUE_WIDTH'(1) - v2;
                end
            end
            MODE_ALIGN: begin
                n_s1_kind = KIND_ALIGN;
                n_s1_x    = '0;
            end
            default: begin
                n_s1_kind = KIND_RAW;
                n_s1_x    = v;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && s1_ready) begin
            r_s1_kind <= n_s1_kind;
            r_s1_x    <= n_s1_x;
            r_s1_bc   <= i_bit_count;
        end
    end

    // bit length of the code number: highest set bit wins
    always_comb begin
        len = '0;
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            if (r_s1_x[i]) begin
                len = LEN_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_s2_count = '0;
        n_s2_shift = SHIFT_W'(CODE_W);
        unique case (r_s1_kind)
            KIND_RAW: begin
                n_s2_count = CNT_W'(r_s1_bc);
                n_s2_shift = SHIFT_W'(CODE_W) - SHIFT_W'(r_s1_bc);
            end
            KIND_GOLOMB: begin
                // len-1 zeros then len bits of x: x itself in 2*len-1 bits
                if (len != '0) begin
                    n_s2_count = CNT_W'({len, 1'b0} - 1'b1);
                    n_s2_shift = SHIFT_W'(CODE_W + 1) - SHIFT_W'({len, 1'b0});
                end
            end
            KIND_ALIGN: begin
                n_s2_count = '0;
            end
            default: begin
                n_s2_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s2_ready) begin
            r_s2_x     <= r_s1_x;
            r_s2_shift <= n_s2_shift;
            r_s2_count <= n_s2_count;
            r_s2_align <= (r_s1_kind == KIND_ALIGN);
        end
    end

    assign o_valid       = r_s2_valid;
    assign o_entry.word  = CODE_W'(r_s2_x) << r_s2_shift;
    assign o_entry.count = r_s2_count;
    assign o_entry.align = r_s2_align;

endmodule

// ===== src/egbw_queue.sv =====
module egbw_queue import egbw_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_entry i_entry,
    output logic   o_valid,
    input  logic   i_ready,
    output t_entry o_entry
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_fill;
    logic              push;
    logic              pop;

    assign o_ready = (r_fill != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== src/egbw_back.sv =====
module egbw_back import egbw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_entry     i_entry,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast
);

    // bits pending, left-justified at the top; bits below r_cnt stay zero
    logic [ACC_W-1:0]     r_acc;
    logic [ACC_CNT_W-1:0] r_cnt;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic                 emit;
    logic                 load;
    logic [ACC_W-1:0]     acc_e;
    logic [ACC_CNT_W-1:0] cnt_e;
    logic [ACC_W-1:0]     ins;
    logic [2:0]           pad_cnt;
    logic [ACC_CNT_W-1:0] add_cnt;
    logic [ACC_W-1:0]     n_acc;
    logic [ACC_CNT_W-1:0] n_cnt;

    always_comb begin
        emit    = (r_cnt >= ACC_CNT_W'(8)) && (!r_out_valid || i_tready);
        acc_e   = emit ? (r_acc << 8) : r_acc;
        cnt_e   = emit ? (r_cnt - ACC_CNT_W'(8)) : r_cnt;
        // a new item joins only the leftover partial byte
        load    = i_valid && (cnt_e < ACC_CNT_W'(8));
        ins     = {i_entry.word, 8'b0} >> cnt_e[2:0];
        pad_cnt = 3'd0 - cnt_e[2:0];
        add_cnt = i_entry.align ? ACC_CNT_W'(pad_cnt) : ACC_CNT_W'(i_entry.count);
        n_acc   = load ? (acc_e | ins) : acc_e;
        n_cnt   = load ? (cnt_e + add_cnt) : cnt_e;
    end

    assign o_ready = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= r_acc[ACC_W-1 -: 8];
            // fewer than 8 bits left afterwards: final byte of its item
            r_out_last <= (r_cnt < ACC_CNT_W'(16));
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_byte;
    assign o_tlast  = r_out_last;

endmodule

// ===== src/exp_golomb_bit_writer.sv =====
// Exp-Golomb bitstream writer for video header syntax.
//
// Input stream: one item per handshake (tvalid & tready). Each item is a
// raw bit field, an unsigned or signed order-0 Exp-Golomb code, or a
// request to pad with zeros up to the next byte boundary.
// Output stream: one completed byte per handshake, first written bit in the
// MSB; tlast flags the final byte completed by an input item. An item that
// completes no byte produces nothing on the output.
//
// Front end: two register stages (code number, then length and left
// justification) feed a 4-entry queue. Back end: a 72-bit accumulator
// that merges each item behind the leftover partial byte and drains one
// byte per cycle, while the receiver takes them, into an output register.
// The back end takes one item per cycle while items complete at most one
// byte and the receiver takes every byte; an item completing more bytes
// holds the back end until they have drained, up to 8 bytes for one item.
// Reset (synchronous, active low) empties the pipeline and queue and
// clears the partial byte. When the receiver stalls the output register
// holds its byte, the accumulator and queue fill, and tready on the input
// drops once the queue and both front stages are full.
module exp_golomb_bit_writer import egbw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [1:0] mode, [33:2] value, [39:34] bit_count
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    logic   front_valid;
    logic   front_ready;
    t_entry front_entry;
    logic   queue_valid;
    logic   queue_ready;
    t_entry queue_entry;

    // classify and place the bits of each item
    egbw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_mode      (i_s_axis_tdata[1:0]),
        .i_value     (i_s_axis_tdata[33:2]),
        .i_bit_count (i_s_axis_tdata[39:34]),
        .o_valid     (front_valid),
        .i_ready     (front_ready),
        .o_entry     (front_entry)
    );

    // lets the front keep accepting while the back drains long codes
    egbw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_entry (front_entry),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_entry (queue_entry)
    );

    // byte packer with registered output
    egbw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .o_ready  (queue_ready),
        .i_entry  (queue_entry),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule

// ===== verif/tb_exp_golomb_bit_writer.sv =====
`timescale 1ns / 1ps

module tb_exp_golomb_bit_writer;
    import egbw_pkg::*;

    localparam int HOLD_CYCLES  = 100;   // long output hold-off during the burst phase
    localparam int IDLE_LIMIT   = 2000;  // watchdog: cycles with no handshake on either side
    localparam int TAIL_CYCLES  = 30;
    localparam int REPORT_MAX   = 10;

    // One directed row. Where typed is set, the bytes come straight from the row
    // (first byte in [63:56]) and the predictor only tracks the partial byte.
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
        logic [5:0]  count;
        logic        typed;
        logic [3:0]  n_typed;
        logic [63:0] typed_bytes;
    } t_dir_row;

    typedef struct {
        logic [7:0] val;
        logic       last;
    } t_out_byte;

    localparam int DIR_ROWS = 24;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        // raw fields from an aligned start
        {MODE_RAW,   32'h0000_00A5,  6'd8, 1'b1, 4'd1, 64'hA500_0000_0000_0000},
        {MODE_RAW,   32'hDEAD_BEEF, 6'd32, 1'b1, 4'd4, 64'hDEAD_BEEF_0000_0000},
        // zero count writes nothing
        {MODE_RAW,   32'hFFFF_FFFF,  6'd0, 1'b1, 4'd0, 64'h0},
        // unsigned code of all ones wraps: nothing written
        {MODE_UE,    32'hFFFF_FFFF,  6'd0, 1'b1, 4'd0, 64'h0},
        // align while aligned
        {MODE_ALIGN, 32'h0000_0000,  6'd0, 1'b1, 4'd0, 64'h0},
        // widest raw field: 31 zero-extension bits, then the 32 value bits
        {MODE_RAW,   32'hFFFF_FFFF, 6'd63, 1'b1, 4'd7, 64'h0000_0001_FFFF_FF00},
        {MODE_ALIGN, 32'h0000_0000,  6'd0, 1'b1, 4'd1, 64'hFE00_0000_0000_0000},
        {MODE_UE,    32'h0000_0000,  6'd0, 1'b0, 4'd0, 64'h0},
        {MODE_UE,    32'h0000_0001,  6'd0, 1'b0, 4'd0, 64'h0},
        {MODE_UE,    32'hFFFF_FFFE,  6'd0, 1'b0, 4'd0, 64'h0},
        {MODE_SE,    32'h0000_0000,  6'd0, 1'b0, 4'd0, 64'h0},
        {MODE_SE,    32'h0000_0001,  6'd0, 1'b0, 4'd0, 64'h0},
        {MODE_SE,    32'hFFFF_FFFF,  6'd0, 1'b0, 4'd0, 64'h0},
        {MODE_SE,    32'h7FFF_FFFF,  6'd0, 1'b0, 4'd0, 64'h0},
        // most negative signed value: code wraps, single one bit
        {MODE_SE,    32'h8000_0000,  6'd0, 1'b0, 4'd0, 64'h0},
        {MODE_ALIGN, 32'h0000_0000,  6'd0, 1'b0, 4'd0, 64'h0},
        {MODE_RAW,   32'h0000_0005,  6'd3, 1'b0, 4'd0, 64'h0},
        {MODE_RAW,   32'h1234_5678, 6'd33, 1'b0, 4'd0, 64'h0},
        {MODE_RAW,   32'hFFFF_FFFF,  6'd1, 1'b0, 4'd0, 64'h0},
        {MODE_UE,    32'h7FFF_FFFF,  6'd0, 1'b0, 4'd0, 64'h0},
        {MODE_SE,    32'h8000_0001,  6'd0, 1'b0, 4'd0, 64'h0},
        {MODE_ALIGN, 32'h0000_0000,  6'd0, 1'b0, 4'd0, 64'h0},
        {MODE_RAW,   32'h0000_0000, 6'd63, 1'b1, 4'd7, 64'h0},
        {MODE_ALIGN, 32'h0000_0000,  6'd0, 1'b1, 4'd1, 64'h0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;    // [1:0] mode, [33:2] value, [39:34] bit_count
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;    // [7:0] out_byte
    logic        o_m_axis_tlast;

    exp_golomb_bit_writer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Bit packer copy: unfinished byte, right-justified, and its bit count.
    logic [6:0]  pend_bits;
    int unsigned pend_cnt;
    logic [7:0]  item_bytes [$];        // bytes completed by the item being predicted
    t_out_byte   expected_bytes [$];    // in flight through the block, oldest first

    int  mismatches;
    int  bytes_checked;
    int  lasts_checked;
    int  items_per_mode [4];
    int  idle_cycles;
    logic tx_steady;
    logic hold_req;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ---- predictor ----
    function automatic void put_bit(logic b);
        if (pend_cnt == 7) begin
            item_bytes.insert(item_bytes.size(), {pend_bits, b});
            pend_bits = '0;
            pend_cnt  = 0;
        end else begin
            pend_bits = {pend_bits[5:0], b};
            pend_cnt++;
        end
    endfunction

    // MSB first; bits above the value width are zero by extension
    function automatic void put_field(logic [63:0] w, int n);
        for (int i = n - 1; i >= 0; i--)
            put_bit(w[i]);
    endfunction

    function automatic void put_golomb(logic [31:0] code);
        logic [31:0] x;
        int          len;
        x   = code + 32'd1;
        len = 0;
        if (x == '0) return;            // wrapped code number: nothing written
        for (int i = 0; i < 32; i++)
            if (x[i]) len = i + 1;
        put_field(64'd0, len - 1);
        put_field({32'd0, x}, len);
    endfunction

    function automatic void encode_item(logic [1:0] mode, logic [31:0] value,
                                        logic [5:0] count);
        item_bytes.delete();
        case (mode)
            MODE_RAW: begin
                put_field({32'd0, value}, int'(count));
            end
            MODE_UE: begin
                put_golomb(value);
            end
            MODE_SE: begin
                if (!value[31] && value != '0)
                    put_golomb((value << 1) - 32'd1);
                else
                    put_golomb(32'd0 - (value << 1));
            end
            default: begin
                while (pend_cnt != 0)
                    put_bit(1'b0);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // ---- input side ----
    task automatic send_item(input logic [1:0] mode, input logic [31:0] value,
                             input logic [5:0] count, input logic typed,
                             input logic [3:0] n_typed, input logic [63:0] typed_bytes);
        int        gap;
        t_out_byte ob;
        gap = tx_steady ? 0 : idle_len();
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {count, value, mode};
        do @(posedge i_clk); while (!o_s_axis_tready);

        items_per_mode[mode]++;
        encode_item(mode, value, count);
        if (typed) begin
            for (int k = 0; k < n_typed; k++) begin
                ob.val  = typed_bytes[63 - 8 * k -: 8];
                ob.last = (k == n_typed - 1);
                expected_bytes.insert(expected_bytes.size(), ob);
            end
        end else begin
            foreach (item_bytes[k]) begin
                ob.val  = item_bytes[k];
                ob.last = (k == item_bytes.size() - 1);
                expected_bytes.insert(expected_bytes.size(), ob);
            end
        end
    endtask

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3: return $urandom_range(0, 20);
            4, 5, 6:    return $urandom >> $urandom_range(0, 31);
            7:          return $urandom;
            8: begin
                r = $urandom_range(0, 3);
                if (r == 0) return 32'h0000_0000;
                if (r == 1) return 32'hFFFF_FFFF;
                if (r == 2) return 32'h7FFF_FFFF;
                return 32'h8000_0000;
            end
            default:    return 32'd0 - $urandom_range(1, 20);
        endcase
    endfunction

    task automatic random_item(input logic long_codes);
        int          r;
        logic [1:0]  mode;
        logic [31:0] value;
        logic [5:0]  count;
        r = $urandom_range(0, 99);
        if (r < 30)      mode = MODE_RAW;
        else if (r < 60) mode = MODE_UE;
        else if (r < 90) mode = MODE_SE;
        else             mode = MODE_ALIGN;
        value = long_codes ? $urandom : pick_value();
        if (long_codes)                      count = 6'($urandom_range(24, 32));
        else if ($urandom_range(0, 9) < 7)   count = 6'($urandom_range(0, 32));
        else                                 count = 6'($urandom_range(33, 63));
        send_item(mode, value, count, 1'b0, 4'd0, 64'd0);
    endtask

    // lower valid and wait for every predicted byte to come out
    task automatic drain_pause();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        int k;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        pend_bits       = '0;
        pend_cnt        = 0;
        mismatches      = 0;
        bytes_checked   = 0;
        lasts_checked   = 0;
        tx_steady       = 1'b0;
        hold_req        = 1'b0;
        foreach (items_per_mode[m]) items_per_mode[m] = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: extremes, every mode, wrap and alignment corner cases
        for (k = 0; k < DIR_ROWS; k++)
            send_item(DIR_TAB[k].mode, DIR_TAB[k].value, DIR_TAB[k].count,
                      DIR_TAB[k].typed, DIR_TAB[k].n_typed, DIR_TAB[k].typed_bytes);
        drain_pause();

        // random mix with idling on both sides
        for (k = 0; k < 60; k++) begin
            if (k % 20 == 0) tx_steady = ($urandom_range(0, 3) == 0);
            random_item(1'b0);
        end
        drain_pause();

        // output held off while long codes arrive back to back: input must stall
        hold_req  = 1'b1;
        tx_steady = 1'b1;
        for (k = 0; k < 40; k++)
            random_item(1'b1);
        drain_pause();

        for (k = 0; k < 56; k++) begin
            if (k % 20 == 0) tx_steady = ($urandom_range(0, 3) == 0);
            random_item(1'b0);
        end
        drain_pause();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        foreach (expected_bytes[j])
            report_mismatch($sformatf("byte %02h last %0b never came out",
                                      expected_bytes[j].val, expected_bytes[j].last));
        $display("Covered %0d items: raw %0d, unsigned %0d, signed %0d, align %0d",
                 items_per_mode[MODE_RAW] + items_per_mode[MODE_UE] +
                 items_per_mode[MODE_SE] + items_per_mode[MODE_ALIGN],
                 items_per_mode[MODE_RAW], items_per_mode[MODE_UE],
                 items_per_mode[MODE_SE], items_per_mode[MODE_ALIGN]);
        $display("%0d output bytes compared (%0d ending an item), one %0d-cycle output hold-off",
                 bytes_checked, lasts_checked, HOLD_CYCLES);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ---- output side: random backpressure plus one long hold-off on request ----
    initial begin : receiver
        int   stall_left;
        int   phase_left;
        logic steady;
        stall_left      = 0;
        phase_left      = 0;
        steady          = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    steady     = ($urandom_range(0, 3) == 0);
                    phase_left = $urandom_range(20, 80);
                end
                phase_left--;
                if (stall_left > 0) begin
                    stall_left--;
                    i_m_axis_tready <= 1'b0;
                end else if (steady || $urandom_range(0, 2) != 0) begin
                    i_m_axis_tready <= 1'b1;
                end else begin
                    stall_left = idle_len();
                    i_m_axis_tready <= 1'b0;
                end
            end
        end
    end

    // compare every accepted byte with the oldest prediction
    always @(posedge i_clk) begin : byte_check
        t_out_byte ob;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("byte %02h last %0b with nothing expected",
                                          o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                ob = expected_bytes.pop_front();
                bytes_checked++;
                if (ob.last) lasts_checked++;
                if (o_m_axis_tdata !== ob.val)
                    report_mismatch($sformatf("out_byte expected %02h, got %02h",
                                              ob.val, o_m_axis_tdata));
                if (o_m_axis_tlast !== ob.last)
                    report_mismatch($sformatf("last expected %0b, got %0b (byte %02h)",
                                              ob.last, o_m_axis_tlast, ob.val));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout after %0d cycles without a handshake", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule

// ===== exp_golomb_bit_writer.f =====
src/egbw_pkg.sv
src/egbw_front.sv
src/egbw_queue.sv
src/egbw_back.sv
src/exp_golomb_bit_writer.sv
verif/tb_exp_golomb_bit_writer.sv
